[rtl/maxout_group_max_with_gradient_assert.svh]
// ----------------------------------------------------------------------------
// Maxout assertion macros
// Concurrent assertion helpers for the maxout block. They expand to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MAXOUT_GROUP_MAX_WITH_GRADIENT_ASSERT_SVH
`define MAXOUT_GROUP_MAX_WITH_GRADIENT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define MGM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("maxout: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("maxout: assertion failed");

`else

`define MGM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/maxout_pkg.sv]
// ----------------------------------------------------------------------------
// Maxout package
// Beat types, register map and shared constants of the maxout block.
// ----------------------------------------------------------------------------
package maxout_pkg;

  localparam int unsigned VAL_W         = 16;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned GROUP_SIZE_W  = 5;
  localparam int unsigned OUT_COLUMNS_W = 7;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned APB_ADDR_W    = 4;

  localparam int unsigned MAX_GROUP_DEF   = 16;
  localparam int unsigned MAX_OUTPUTS_DEF = 64;
  localparam int unsigned MAX_ROWS_DEF    = 16;

  localparam logic [GROUP_SIZE_W-1:0]  GROUP_SIZE_RST  = GROUP_SIZE_W'(2);
  localparam logic [OUT_COLUMNS_W-1:0] OUT_COLUMNS_RST = OUT_COLUMNS_W'(64);
  localparam logic                     TRAIN_MODE_RST  = 1'b1;
  localparam logic                     FIRST_LAYER_RST = 1'b0;

  // Beat kinds on both channels.
  localparam logic KIND_FORWARD  = 1'b0;
  localparam logic KIND_BACKWARD = 1'b1;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_GROUP_SIZE  = 2'd0,
    REG_OUT_COLUMNS = 2'd1,
    REG_TRAIN_MODE  = 2'd2,
    REG_FIRST_LAYER = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                    kind;
    logic                    start_batch;
    logic signed [VAL_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic                    result_kind;
    logic signed [VAL_W-1:0] result_value;
    logic [POS_W-1:0]        position;
    logic                    last;
  } out_t;

endpackage

[rtl/maxout_group_max_with_gradient.sv]
// ----------------------------------------------------------------------------
// Maxout group maximum with gradient routing
// Forward pass: maximum of each group of inputs and its column. Backward
// pass: scatters an output gradient to the stored winning column.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid_i / in_ready_o / in_data_i) takes one
// beat per value. A forward beat carries one activation of a row in
// row-major order; every group_size-th forward beat closes a group and
// produces one result beat with the group maximum and its input column.
// A backward beat carries one output gradient and produces group_size
// result beats: the gradient at the column stored during the forward pass
// and zero elsewhere, the final one flagged by last. With first_layer set,
// backward beats are consumed without any result.
// A result passes the expansion stage, then the output register. Forward
// beats are taken one per cycle while in_ready_o is high. A backward beat
// holds the expansion stage while its group_size results go out, one per
// cycle unless the output port stalls. The argmax store is a single-port
// synchronous RAM of MAX_ROWS * MAX_OUTPUTS entries. Reset clears the
// configuration to its defaults and all counters, not the store; the user
// must read only entries written in train mode; the block does not check.
// When the receiver stalls, the output register holds its beat, the
// expansion stage holds behind it, and in_ready_o stays low until the
// expansion stage hands its last result to the output register.
// Configuration goes through the APB port, registers at 0x0, 0x4, 0x8, 0xC.
// ----------------------------------------------------------------------------
`include "maxout_group_max_with_gradient_assert.svh"

module maxout_group_max_with_gradient
  import maxout_pkg::*;
#(
  parameter int unsigned MAX_GROUP   = MAX_GROUP_DEF,
  parameter int unsigned MAX_OUTPUTS = MAX_OUTPUTS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input beats
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_t                   in_data_i,
  // Result beats
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_t                  out_data_o,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Effective group size and column count may reach the maximum itself;
  // the counters only hold values below it.
  localparam int unsigned GW    = $clog2(MAX_GROUP + 1);
  localparam int unsigned EW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CNW   = $clog2(MAX_OUTPUTS + 1);
  localparam int unsigned CW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned DEPTH = MAX_ROWS * MAX_OUTPUTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GROUP_SIZE_W-1:0]  group_size_q;
  logic [OUT_COLUMNS_W-1:0] out_columns_q;
  logic                     train_mode_q;
  logic                     first_layer_q;
  logic                     cfg_wr;
  reg_idx_e                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q  <= GROUP_SIZE_RST;
      out_columns_q <= OUT_COLUMNS_RST;
      train_mode_q  <= TRAIN_MODE_RST;
      first_layer_q <= FIRST_LAYER_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_GROUP_SIZE:  group_size_q  <= pwdata[GROUP_SIZE_W-1:0];
        REG_OUT_COLUMNS: out_columns_q <= pwdata[OUT_COLUMNS_W-1:0];
        REG_TRAIN_MODE:  train_mode_q  <= pwdata[0];
        REG_FIRST_LAYER: first_layer_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_GROUP_SIZE:  prdata = APB_DATA_W'(group_size_q);
      REG_OUT_COLUMNS: prdata = APB_DATA_W'(out_columns_q);
      REG_TRAIN_MODE:  prdata = APB_DATA_W'(train_mode_q);
      REG_FIRST_LAYER: prdata = APB_DATA_W'(first_layer_q);
      default:         prdata = '0;
    endcase
  end

  // A zero register means one; values above the maximum are clipped to it.
  logic [GW-1:0]  g_eff;
  logic [CNW-1:0] cols_eff;

  always_comb begin
    if (group_size_q == '0) begin
      g_eff = GW'(1);
    end else if (32'(group_size_q) > MAX_GROUP) begin
      g_eff = GW'(MAX_GROUP);
    end else begin
      g_eff = GW'(group_size_q);
    end
    if (out_columns_q == '0) begin
      cols_eff = CNW'(1);
    end else if (32'(out_columns_q) > MAX_OUTPUTS) begin
      cols_eff = CNW'(MAX_OUTPUTS);
    end else begin
      cols_eff = CNW'(out_columns_q);
    end
  end

  // --------------------------------------------------------------------------
  // Counter and running-maximum state
  // --------------------------------------------------------------------------
  logic [EW-1:0]           elem_q, elem_d;
  logic [CW-1:0]           fcol_q, fcol_d;
  logic [RW-1:0]           frow_q, frow_d;
  logic [CW-1:0]           bcol_q, bcol_d;
  logic [RW-1:0]           brow_q, brow_d;
  logic signed [VAL_W-1:0] rmax_q, rmax_d;
  logic [POS_W-1:0]        rpos_q, rpos_d;

  logic in_accept;
  logic fwd_acc;
  logic bwd_acc;

  assign in_accept = in_valid_i && in_ready_o;
  assign fwd_acc   = in_accept && (in_data_i.kind == KIND_FORWARD);
  assign bwd_acc   = in_accept && (in_data_i.kind == KIND_BACKWARD) && !first_layer_q;

  // Forward beat: start of batch clears the counters first, then counters
  // left out of range by a register change fold back to zero.
  logic [EW-1:0]           f_eig_raw, f_eig;
  logic [CW-1:0]           f_col_raw, f_col, f_col_next;
  logic [RW-1:0]           f_row, f_row_next;
  logic [POS_W-1:0]        f_pos, f_pos_win;
  logic signed [VAL_W-1:0] f_max;
  logic                    f_take, f_done, f_col_wrap;
  logic [AW-1:0]           f_addr;

  always_comb begin
    f_eig_raw  = in_data_i.start_batch ? '0 : elem_q;
    f_eig      = (GW'(f_eig_raw) >= g_eff) ? '0 : f_eig_raw;
    f_col_raw  = in_data_i.start_batch ? '0 : fcol_q;
    f_col      = (CNW'(f_col_raw) >= cols_eff) ? '0 : f_col_raw;
    f_row      = in_data_i.start_batch ? '0 : frow_q;
    f_pos      = POS_W'(32'(g_eff) * 32'(f_col) + 32'(f_eig));
    // Strictly greater keeps the first of equal values.
    f_take     = (f_eig == '0) || (in_data_i.sample_value > rmax_q);
    f_max      = f_take ? in_data_i.sample_value : rmax_q;
    f_pos_win  = f_take ? f_pos : rpos_q;
    f_done     = (GW'(f_eig) + GW'(1)) >= g_eff;
    f_col_wrap = (CNW'(f_col) + CNW'(1)) >= cols_eff;
    f_col_next = f_col_wrap ? '0 : f_col + CW'(1);
    f_row_next = (32'(f_row) == MAX_ROWS - 1) ? '0 : f_row + RW'(1);
    f_addr     = AW'(32'(f_row) * MAX_OUTPUTS + 32'(f_col));
  end

  // Backward beat: same folding on its own row and column counters.
  logic [CW-1:0]    b_col_raw, b_col, b_col_next;
  logic [RW-1:0]    b_row, b_row_next;
  logic [POS_W-1:0] b_base;
  logic             b_col_wrap;
  logic [AW-1:0]    b_addr;

  always_comb begin
    b_col_raw  = in_data_i.start_batch ? '0 : bcol_q;
    b_col      = (CNW'(b_col_raw) >= cols_eff) ? '0 : b_col_raw;
    b_row      = in_data_i.start_batch ? '0 : brow_q;
    b_base     = POS_W'(32'(g_eff) * 32'(b_col));
    b_col_wrap = (CNW'(b_col) + CNW'(1)) >= cols_eff;
    b_col_next = b_col_wrap ? '0 : b_col + CW'(1);
    b_row_next = (32'(b_row) == MAX_ROWS - 1) ? '0 : b_row + RW'(1);
    b_addr     = AW'(32'(b_row) * MAX_OUTPUTS + 32'(b_col));
  end

  always_comb begin
    elem_d = elem_q;
    fcol_d = fcol_q;
    frow_d = frow_q;
    rmax_d = rmax_q;
    rpos_d = rpos_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    if (fwd_acc) begin
      rmax_d = f_max;
      rpos_d = f_pos_win;
      if (f_done) begin
        elem_d = '0;
        fcol_d = f_col_next;
        frow_d = f_col_wrap ? f_row_next : f_row;
      end else begin
        elem_d = f_eig + EW'(1);
        fcol_d = f_col;
        frow_d = f_row;
      end
    end
    if (bwd_acc) begin
      bcol_d = b_col_next;
      brow_d = b_col_wrap ? b_row_next : b_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= '0;
      fcol_q <= '0;
      frow_q <= '0;
      bcol_q <= '0;
      brow_q <= '0;
      rmax_q <= '0;
      rpos_q <= '0;
    end else begin
      elem_q <= elem_d;
      fcol_q <= fcol_d;
      frow_q <= frow_d;
      bcol_q <= bcol_d;
      brow_q <= brow_d;
      rmax_q <= rmax_d;
      rpos_q <= rpos_d;
    end
  end

  // --------------------------------------------------------------------------
  // Argmax store. At most one beat is accepted per cycle and it either writes (a
  // forward beat closing a group) or reads (a backward beat), never both, so
  // a read always sees every earlier write and needs no forwarding path.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] argmax_mem [DEPTH];
  logic [POS_W-1:0] rdata_q;
  logic             mem_we;

  assign mem_we = fwd_acc && f_done && train_mode_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      argmax_mem[f_addr] <= f_pos_win;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bwd_acc) begin
      rdata_q <= argmax_mem[b_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Expansion stage. Holds one beat that has results: a closed forward group
  // (one result) or a backward gradient (group_size results, k counting).
  // The read data of the store lines up with this stage.
  // --------------------------------------------------------------------------
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_kind_q;
  logic signed [VAL_W-1:0] s1_value_q;
  logic [POS_W-1:0]        s1_pos_q;
  logic [GW-1:0]           s1_g_q;
  logic [EW-1:0]           s1_k_q, s1_k_d;
  logic                    s1_load;
  logic                    s1_done;

  logic [POS_W-1:0]        e_pos;
  logic signed [VAL_W-1:0] e_value;
  logic                    e_last;

  logic out_valid_q, out_valid_d;
  out_t out_q;
  logic out_load;

  assign s1_load = (fwd_acc && f_done) || bwd_acc;

  // Forward results sit at k = 0, so one formula serves both kinds.
  assign e_pos   = s1_pos_q + POS_W'(s1_k_q);
  assign e_last  = (s1_kind_q == KIND_FORWARD) || ((GW'(s1_k_q) + GW'(1)) == s1_g_q);
  assign e_value = ((s1_kind_q == KIND_FORWARD) || (e_pos == rdata_q)) ? s1_value_q : '0;

  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_done    = out_load && e_last;
  assign in_ready_o = !s1_valid_q || s1_done;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = s1_load;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
    s1_k_d = s1_k_q;
    if (s1_done) begin
      s1_k_d = '0;
    end else if (out_load) begin
      s1_k_d = s1_k_q + EW'(1);
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_k_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s1_k_q      <= s1_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_kind_q  <= in_data_i.kind;
      s1_value_q <= bwd_acc ? in_data_i.sample_value : f_max;
      s1_pos_q   <= bwd_acc ? b_base : f_pos_win;
      s1_g_q     <= g_eff;
    end
    if (out_load) begin
      out_q.result_kind  <= s1_kind_q;
      out_q.result_value <= e_value;
      out_q.position     <= e_pos;
      out_q.last         <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The element counter never passes the group size captured with the beat.
  `MGM_ASSERT_IMPLY(a_k_in_group, clk_i, rst_ni, s1_valid_q, GW'(s1_k_q) < s1_g_q)
  // Finishing a beat leaves the counter ready for the next one.
  `MGM_ASSERT_NEXT(a_k_cleared, clk_i, rst_ni, s1_done, s1_k_q == '0)
  // Every forward result closes its run.
  `MGM_ASSERT_IMPLY(a_fwd_last, clk_i, rst_ni, out_valid_o && (out_data_o.result_kind == KIND_FORWARD), out_data_o.last)

endmodule
